// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the sender window rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check, disabled while in reset
`define SRSW_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication check, disabled while in reset
`define SRSW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/srsw_pkg.sv =====
// ----------------------------------------------------------------------------
// srsw_pkg
// shared types, codes and widths of the selective repeat sender window
// ----------------------------------------------------------------------------
package srsw_pkg;

	localparam int SLOT_COUNT_DEF  = 32;
	localparam int WINDOW_MAX_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int MODE_W     = 2;
	localparam int HANDLE_W   = 32;
	localparam int LENGTH_W   = 16;
	localparam int ACK_W      = 8;
	localparam int KIND_W     = 3;
	localparam int SEQ_W      = 5;
	localparam int TIME_W     = 16;
	localparam int WSIZE_W    = 5;
	localparam int SEQMAX_W   = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CALC_W     = 9;

	typedef enum logic [MODE_W-1:0] {
		MODE_MSG  = 2'd0,
		MODE_ACK  = 2'd1,
		MODE_TICK = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		RK_SENT    = 3'd0,
		RK_RESENT  = 3'd1,
		RK_ACKED   = 3'd2,
		RK_UNSENT  = 3'd3,
		RK_DUP     = 3'd4,
		RK_FULL    = 3'd5,
		RK_NONE    = 3'd6
	} res_kind_t;

	typedef enum logic [1:0] {
		SS_UNSENT = 2'd0,
		SS_SENT   = 2'd1,
		SS_ACKED  = 2'd2
	} slot_st_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_SIZE = 2'd0,
		CFG_SEQ_MAX     = 2'd1,
		CFG_TIMEOUT     = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		res_kind_t             kind;
		logic [SEQ_W-1:0]      seq;
		logic                  fkind;
		logic [HANDLE_W-1:0]   handle;
		logic [LENGTH_W-1:0]   length;
		logic                  last;
	} result_t;

endpackage

// ===== rtl/srsw_if.sv =====
// ----------------------------------------------------------------------------
// srsw_if
// valid/ready channels of the sender window: input item, result, config
// ----------------------------------------------------------------------------
interface srsw_item_if;
	import srsw_pkg::*;
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [HANDLE_W-1:0] payload_handle;
	logic [LENGTH_W-1:0] payload_bytes;
	logic [ACK_W-1:0]    ack_seq;
	modport source (output valid, mode, payload_handle, payload_bytes, ack_seq,
		input ready);
	modport sink (input valid, mode, payload_handle, payload_bytes, ack_seq,
		output ready);
endinterface

interface srsw_result_if;
	import srsw_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   result_kind;
	logic [SEQ_W-1:0]    frame_seq;
	logic                frame_kind;
	logic [HANDLE_W-1:0] frame_handle;
	logic [LENGTH_W-1:0] frame_length;
	logic                last_result;
	modport source (output valid, result_kind, frame_seq, frame_kind, frame_handle,
		frame_length, last_result, input ready);
	modport sink (input valid, result_kind, frame_seq, frame_kind, frame_handle,
		frame_length, last_result, output ready);
endinterface

interface srsw_cfg_if;
	import srsw_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/srsw_rem.sv =====
// ----------------------------------------------------------------------------
// srsw_rem
// bit-serial restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module srsw_rem #(
	parameter int DVD_W = 8,
	parameter int DVS_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVS_W-1:0] remainder
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	typedef enum logic {R_IDLE, R_RUN} rem_state_t;

	rem_state_t       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic             done_q;
	logic [DVS_W:0]   trial;

	// shift in next dividend bit
	assign trial = {rem_q, dvd_q[DVD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			cnt_q   <= '0;
			dvd_q   <= '0;
			dvs_q   <= '0;
			rem_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: begin
					if (start) begin
						dvd_q   <= dividend;
						dvs_q   <= divisor;
						rem_q   <= '0;
						cnt_q   <= CNT_W'(DVD_W);
						state_q <= R_RUN;
					end
				end
				R_RUN: begin
					if (trial >= {1'b0, dvs_q}) begin
						rem_q <= DVS_W'(trial - {1'b0, dvs_q});
					end else begin
						rem_q <= trial[DVS_W-1:0];
					end
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						done_q  <= 1'b1;
						state_q <= R_IDLE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/selective_repeat_sender_window_core.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_core: selective repeat arq sender window
// folds three pointers (and the ack on an ack), then checks and sends frame by frame
// items: one at a time; a tick walks the window slot by slot, then finishes
// reset: async, clears slot status, pointers, queue count and time, no sweep
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module selective_repeat_sender_window_core #(
	parameter int SLOT_COUNT  = srsw_pkg::SLOT_COUNT_DEF,
	parameter int WINDOW_MAX  = srsw_pkg::WINDOW_MAX_DEF,
	parameter int QUEUE_DEPTH = srsw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	srsw_item_if.sink  item,
	srsw_result_if.source result,
	srsw_cfg_if.sink   cfg
);
	import srsw_pkg::*;

	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int WIN_W  = $clog2(WINDOW_MAX + 1);
	localparam int QW     = $clog2(QUEUE_DEPTH);
	localparam int DVS_W  = SLOT_W + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_FOLD_GO, S_FOLD_WAIT, S_ENQ, S_ACK_ST, S_SLIDE,
		S_SEND_CHK, S_SEND_WR, S_TICK_GO, S_TICK_CHK, S_TICK_CMP, S_FINISH
	} state_t;

	typedef enum logic [1:0] {FS_WS, FS_WE, FS_NS, FS_ACK} fold_sel_t;

	// configuration registers
	logic [WSIZE_W-1:0]  wsize_q;
	logic [SEQMAX_W-1:0] seqmax_q;
	logic [TIME_W-1:0]   timeout_q;

	// sequencer state
	state_t              state_q;
	fold_sel_t           fold_sel_q;
	mode_t               mode_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [LENGTH_W-1:0] length_q;
	logic [ACK_W-1:0]    ack_q;
	logic [WIN_W-1:0]    w_q;
	logic [SLOT_W-1:0]   m_q;
	logic [SLOT_W-1:0]   ws_q;
	logic [SLOT_W-1:0]   we_q;
	logic [SLOT_W-1:0]   ns_q;
	logic [SLOT_W-1:0]   i_q;
	logic [SLOT_W-1:0]   ack_idx_q;
	logic [QW-1:0]       pq_head_q;
	logic [QW:0]         pq_count_q;
	logic [TIME_W-1:0]   now_q;
	slot_st_t            status_q [SLOT_COUNT];

	// one-result lookahead so the final word can carry last_result
	result_t             hold_q;
	logic                hold_valid_q;
	result_t             out_q;
	logic                out_valid_q;

	// memories
	logic [HANDLE_W-1:0] pq_handle_mem [QUEUE_DEPTH];
	logic [LENGTH_W-1:0] pq_length_mem [QUEUE_DEPTH];
	logic [SLOT_W:0]     pq_seq_mem    [QUEUE_DEPTH];
	logic [HANDLE_W-1:0] pq_handle_rd_q;
	logic [LENGTH_W-1:0] pq_length_rd_q;
	logic [SLOT_W:0]     pq_seq_rd_q;
	logic [HANDLE_W-1:0] slot_handle_mem [SLOT_COUNT];
	logic [LENGTH_W-1:0] slot_length_mem [SLOT_COUNT];
	logic [TIME_W-1:0]   slot_time_mem   [SLOT_COUNT];
	logic [HANDLE_W-1:0] slot_handle_rd_q;
	logic [LENGTH_W-1:0] slot_length_rd_q;
	logic [TIME_W-1:0]   slot_time_rd_q;

	// combinational helpers
	logic [CALC_W-1:0]   w_c;
	logic [CALC_W-1:0]   m_c;
	logic [SLOT_W:0]     span;
	logic                send_ok;
	logic                pq_full;
	logic [QW:0]         tail_sum;
	logic [QW-1:0]       pq_tail;
	logic [SLOT_W-1:0]   st_addr;
	slot_st_t            st_rd;
	logic [TIME_W-1:0]   age;
	logic                timed_out;
	logic                out_free;
	logic                can_emit;
	logic                emit_req;
	logic                emit_go;
	result_t             emit_res;
	result_t             fin_res;
	logic                pq_we;
	logic                slot_we;
	logic                time_we;
	logic [SLOT_W-1:0]   time_waddr;

	// shared remainder unit
	logic                rem_start;
	logic [ACK_W-1:0]    rem_dividend;
	logic [DVS_W-1:0]    rem_divisor;
	logic                rem_done;
	logic [DVS_W-1:0]    rem_out;

	function automatic logic [SLOT_W-1:0] adv(input logic [SLOT_W-1:0] v,
		input logic [SLOT_W-1:0] m);
		return (v >= m) ? '0 : v + 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// configuration port, always ready
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsize_q   <= WSIZE_W'(1);
			seqmax_q  <= SEQMAX_W'(31);
			timeout_q <= TIME_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_WINDOW_SIZE: wsize_q   <= cfg.data[WSIZE_W-1:0];
				CFG_SEQ_MAX:     seqmax_q  <= cfg.data[SEQMAX_W-1:0];
				CFG_TIMEOUT:     timeout_q <= cfg.data[TIME_W-1:0];
				default: ; // unmapped index is dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// effective window and wrap point, latched when an item is taken
	// ------------------------------------------------------------------
	always_comb begin
		w_c = CALC_W'(wsize_q);
		if (w_c > CALC_W'(WINDOW_MAX)) begin
			w_c = CALC_W'(WINDOW_MAX);
		end
		m_c = CALC_W'(seqmax_q);
		if (m_c < w_c + CALC_W'(1)) begin
			m_c = w_c + CALC_W'(1);
		end
		if (m_c > CALC_W'(SLOT_COUNT - 1)) begin
			m_c = CALC_W'(SLOT_COUNT - 1);
		end
	end

	// ------------------------------------------------------------------
	// window span, queue tail, slot status read and timeout compare
	// ------------------------------------------------------------------
	always_comb begin
		if (we_q >= ws_q) begin
			span = {1'b0, we_q} - {1'b0, ws_q};
		end else begin
			span = {1'b0, we_q} + {1'b0, m_q} + (SLOT_W+1)'(1) - {1'b0, ws_q};
		end
	end

	assign send_ok  = (pq_count_q != '0) && (CALC_W'(span) < CALC_W'(w_q));
	assign pq_full  = (pq_count_q >= (QW+1)'(QUEUE_DEPTH));
	assign tail_sum = {1'b0, pq_head_q} + pq_count_q;
	assign pq_tail  = (tail_sum >= (QW+1)'(QUEUE_DEPTH)) ?
		QW'(tail_sum - (QW+1)'(QUEUE_DEPTH)) : tail_sum[QW-1:0];

	always_comb begin
		case (state_q)
			S_ACK_ST: st_addr = ack_idx_q;
			S_SLIDE:  st_addr = ws_q;
			default:  st_addr = i_q;
		endcase
	end

	assign st_rd     = status_q[st_addr];
	assign age       = now_q - slot_time_rd_q;
	assign timed_out = (age >= timeout_q);

	// ------------------------------------------------------------------
	// result generation: a new word parks in hold_q, the older one moves
	// to the output register, so a stall on result only blocks emits made
	// while a word is held, and the final word
	assign out_free = !out_valid_q || result.ready;
	assign can_emit = !hold_valid_q || out_free;

	always_comb begin
		emit_req = 1'b0;
		emit_res = '{kind: RK_NONE, seq: '0, fkind: 1'b0, handle: '0, length: '0,
			last: 1'b0};
		case (state_q)
			S_ENQ: begin
				emit_req      = pq_full;
				emit_res.kind = RK_FULL;
			end
			S_ACK_ST: begin
				emit_req     = 1'b1;
				emit_res.seq = SEQ_W'(ack_idx_q);
				case (st_rd)
					SS_SENT:  emit_res.kind = RK_ACKED;
					SS_ACKED: emit_res.kind = RK_DUP;
					default:  emit_res.kind = RK_UNSENT;
				endcase
			end
			S_SEND_WR: begin
				emit_req        = 1'b1;
				emit_res.kind   = RK_SENT;
				emit_res.seq    = SEQ_W'(pq_seq_rd_q[SLOT_W-1:0]);
				emit_res.fkind  = pq_seq_rd_q[SLOT_W];
				emit_res.handle = pq_handle_rd_q;
				emit_res.length = pq_length_rd_q;
			end
			S_TICK_CMP: begin
				emit_req        = timed_out;
				emit_res.kind   = RK_RESENT;
				emit_res.seq    = SEQ_W'(i_q);
				emit_res.fkind  = (i_q == m_q);
				emit_res.handle = slot_handle_rd_q;
				emit_res.length = slot_length_rd_q;
			end
			default: ;
		endcase
	end

	assign emit_go = emit_req && can_emit;

	// final word: held result, or "nothing" when the item produced none
	always_comb begin
		if (hold_valid_q) begin
			fin_res = hold_q;
		end else begin
			fin_res = '{kind: RK_NONE, seq: '0, fkind: 1'b0, handle: '0, length: '0,
				last: 1'b0};
		end
		fin_res.last = 1'b1;
	end

	// ------------------------------------------------------------------
	// remainder operand select: three pointer folds, then the ack index
	// ------------------------------------------------------------------
	assign rem_start   = (state_q == S_FOLD_GO);
	assign rem_divisor = {1'b0, m_q} + DVS_W'(1);

	always_comb begin
		case (fold_sel_q)
			FS_WS:   rem_dividend = ACK_W'(ws_q);
			FS_WE:   rem_dividend = ACK_W'(we_q);
			FS_NS:   rem_dividend = ACK_W'(ns_q);
			default: rem_dividend = ack_q;
		endcase
	end

	srsw_rem #(
		.DVD_W (ACK_W),
		.DVS_W (DVS_W)
	) u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (rem_dividend),
		.divisor   (rem_divisor),
		.done      (rem_done),
		.remainder (rem_out)
	);

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	assign item.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fold_sel_q   <= FS_WS;
			mode_q       <= MODE_NONE;
			handle_q     <= '0;
			length_q     <= '0;
			ack_q        <= '0;
			w_q          <= '0;
			m_q          <= '0;
			ws_q         <= '0;
			we_q         <= '0;
			ns_q         <= '0;
			i_q          <= '0;
			ack_idx_q    <= '0;
			pq_head_q    <= '0;
			pq_count_q   <= '0;
			now_q        <= '0;
			hold_q       <= '0;
			hold_valid_q <= 1'b0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
			for (int k = 0; k < SLOT_COUNT; k++) begin
				status_q[k] <= SS_UNSENT;
			end
		end else begin
			// output register loads from the lookahead or the final word
			if ((emit_go && hold_valid_q) || ((state_q == S_FINISH) && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_go) begin
				if (hold_valid_q) begin
					out_q <= hold_q;
				end
				hold_q       <= emit_res;
				hold_valid_q <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						mode_q     <= mode_t'(item.mode);
						handle_q   <= item.payload_handle;
						length_q   <= item.payload_bytes;
						ack_q      <= item.ack_seq;
						w_q        <= w_c[WIN_W-1:0];
						m_q        <= m_c[SLOT_W-1:0];
						fold_sel_q <= FS_WS;
						// unused mode touches no window state
						state_q    <= (mode_t'(item.mode) == MODE_NONE) ? S_FINISH : S_FOLD_GO;
					end
				end
				S_FOLD_GO: state_q <= S_FOLD_WAIT;
				S_FOLD_WAIT: begin
					if (rem_done) begin
						unique case (fold_sel_q)
							FS_WS: begin
								ws_q       <= rem_out[SLOT_W-1:0];
								fold_sel_q <= FS_WE;
								state_q    <= S_FOLD_GO;
							end
							FS_WE: begin
								we_q       <= rem_out[SLOT_W-1:0];
								fold_sel_q <= FS_NS;
								state_q    <= S_FOLD_GO;
							end
							FS_NS: begin
								ns_q <= rem_out[SLOT_W-1:0];
								case (mode_q)
									MODE_MSG: state_q <= S_ENQ;
									MODE_ACK: begin
										fold_sel_q <= FS_ACK;
										state_q    <= S_FOLD_GO;
									end
									default: state_q <= S_TICK_GO;
								endcase
							end
							FS_ACK: begin
								ack_idx_q <= rem_out[SLOT_W-1:0];
								state_q   <= S_ACK_ST;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ENQ: begin
					if (pq_full) begin
						// message dropped, no sequence number used
						if (can_emit) begin
							state_q <= S_SEND_CHK;
						end
					end else begin
						pq_count_q <= pq_count_q + 1'b1;
						ns_q       <= adv(ns_q, m_q);
						state_q    <= S_SEND_CHK;
					end
				end
				S_ACK_ST: begin
					if (can_emit) begin
						if (st_rd == SS_SENT) begin
							status_q[ack_idx_q] <= SS_ACKED;
							state_q             <= S_SLIDE;
						end else begin
							state_q <= S_SEND_CHK;
						end
					end
				end
				S_SLIDE: begin
					// slide window start over acknowledged slots, one per cycle
					if ((ws_q != we_q) && (st_rd == SS_ACKED)) begin
						status_q[ws_q] <= SS_UNSENT;
						ws_q           <= adv(ws_q, m_q);
					end else begin
						state_q <= S_SEND_CHK;
					end
				end
				S_SEND_CHK: state_q <= send_ok ? S_SEND_WR : S_FINISH;
				S_SEND_WR: begin
					if (can_emit) begin
						status_q[we_q] <= SS_SENT;
						pq_head_q      <= (pq_head_q == QW'(QUEUE_DEPTH - 1)) ?
							'0 : pq_head_q + 1'b1;
						pq_count_q     <= pq_count_q - 1'b1;
						we_q           <= adv(we_q, m_q);
						state_q        <= S_SEND_CHK;
					end
				end
				S_TICK_GO: begin
					now_q   <= now_q + 1'b1;
					i_q     <= ws_q;
					state_q <= S_TICK_CHK;
				end
				S_TICK_CHK: begin
					if (i_q == we_q) begin
						state_q <= S_FINISH;
					end else if (st_rd == SS_SENT) begin
						state_q <= S_TICK_CMP;
					end else begin
						i_q <= adv(i_q, m_q);
					end
				end
				S_TICK_CMP: begin
					if (!timed_out || can_emit) begin
						i_q     <= adv(i_q, m_q);
						state_q <= S_TICK_CHK;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_q        <= fin_res;
						hold_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// memory write strobes
	// ------------------------------------------------------------------
	assign pq_we      = (state_q == S_ENQ) && !pq_full;
	assign slot_we    = (state_q == S_SEND_WR) && can_emit;
	assign time_we    = (state_q == S_TICK_CMP) && emit_go;
	assign time_waddr = slot_we ? we_q : i_q;

	// pending queue: written at tail, read at head every cycle
	always_ff @(posedge clk) begin
		if (pq_we) begin
			pq_handle_mem[pq_tail] <= handle_q;
			pq_length_mem[pq_tail] <= length_q;
			pq_seq_mem[pq_tail]    <= {(ns_q == m_q), ns_q};
		end
		pq_handle_rd_q <= pq_handle_mem[pq_head_q];
		pq_length_rd_q <= pq_length_mem[pq_head_q];
		pq_seq_rd_q    <= pq_seq_mem[pq_head_q];
	end

	// slot payload: written at window end on send, read at the tick walker
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_handle_mem[we_q] <= pq_handle_rd_q;
			slot_length_mem[we_q] <= pq_length_rd_q;
		end
		slot_handle_rd_q <= slot_handle_mem[i_q];
		slot_length_rd_q <= slot_length_mem[i_q];
	end

	// send time: stamped on send and on every retransmit
	always_ff @(posedge clk) begin
		if (slot_we || time_we) begin
			slot_time_mem[time_waddr] <= now_q;
		end
		slot_time_rd_q <= slot_time_mem[i_q];
	end

	// ------------------------------------------------------------------
	// result port
	// ------------------------------------------------------------------
	assign result.valid        = out_valid_q;
	assign result.result_kind  = out_q.kind;
	assign result.frame_seq    = out_q.seq;
	assign result.frame_kind   = out_q.fkind;
	assign result.frame_handle = out_q.handle;
	assign result.frame_length = out_q.length;
	assign result.last_result  = out_q.last;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`SRSW_ASSERT_IMPLY(a_idle_hold_empty, clk, arst_n, state_q == S_IDLE, !hold_valid_q, "result left in lookahead while idle")
	`SRSW_ASSERT(a_queue_bound, clk, arst_n, pq_count_q <= (QW+1)'(QUEUE_DEPTH), "pending queue count above depth")
	`SRSW_ASSERT_IMPLY(a_send_in_window, clk, arst_n, state_q == S_SEND_WR, CALC_W'(span) < CALC_W'(w_q), "frame sent with window full")

endmodule
